// ----- hdl/five_tuple_firewall_classifier_top_assert.svh -----
// ----------------------------------------------------------------------------
// Firewall classifier assertion macros
// Concurrent check wrappers clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef FIVE_TUPLE_FIREWALL_CLASSIFIER_TOP_ASSERT_SVH
`define FIVE_TUPLE_FIREWALL_CLASSIFIER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define FTFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define FTFC_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);
`else
`define FTFC_ASSERT(lbl, prop, msg)
`define FTFC_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- hdl/ftfc_pkg.sv -----
// ----------------------------------------------------------------------------
// Firewall classifier package
// Table sizes, request and result codes, controller types.
// ----------------------------------------------------------------------------
package ftfc_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;
    localparam int RAM_DEPTH     = 2 * TABLE_ENTRIES;
    localparam int RAM_AW        = IDX_W + 1;
    localparam int KEY_W         = 104;
    localparam int ROW_W         = KEY_W + 8;
    localparam int HELD_W        = 11;

    localparam logic [15:0] ETH_IPV4     = 16'h0800;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [7:0]  ACTION_BLOCK = 8'd1;

    typedef enum logic [1:0] {
        REQ_ADD_PENDING = 2'd0,
        REQ_COMMIT      = 2'd1,
        REQ_ADD_ACTIVE  = 2'd2,
        REQ_CLASSIFY    = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        RES_FORWARD   = 3'd0,
        RES_DROP      = 3'd1,
        RES_NOT_IPV4  = 3'd2,
        RES_STORED    = 3'd3,
        RES_REPLACED  = 3'd4,
        RES_FULL      = 3'd5,
        RES_COMMITTED = 3'd6
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_COMPARE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic clr_idx;
        logic inc_idx;
        logic set_found;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic direct;
        logic empty;
        logic match;
        logic last;
        logic out_busy;
    } sts_t;

endpackage

// ----- hdl/ftfc_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ftfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write and registered read
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

// ----- hdl/ftfc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Firewall classifier controller
// Sequences load, table scan and result write-back for one transaction.
// ----------------------------------------------------------------------------
`include "five_tuple_firewall_classifier_top_assert.svh"
module ftfc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  ftfc_pkg::sts_t sts,
    output ftfc_pkg::cmd_t cmd
);
    import ftfc_pkg::*;

    state_t st_reg, st_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    // next state
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE: begin
                if (s_tvalid) st_next = S_DECODE;
            end
            S_DECODE: begin
                if (sts.direct || sts.empty) st_next = S_FINISH;
                else st_next = S_READ;
            end
            S_READ: st_next = S_COMPARE;
            S_COMPARE: begin
                if (sts.match || sts.last) st_next = S_FINISH;
                else st_next = S_READ;
            end
            S_FINISH: begin
                if (!sts.out_busy) st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (st_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.load    = s_tvalid;
                cmd.clr_idx = s_tvalid;
            end
            S_COMPARE: begin
                cmd.set_found = sts.match;
                cmd.inc_idx   = !sts.match && !sts.last;
            end
            S_FINISH: begin
                cmd.finish = !sts.out_busy;
            end
            default: ;
        endcase
    end

    `FTFC_ASSERT(a_load_decodes, s_tvalid && s_tready |=> st_reg == S_DECODE, "load did not decode")
    `FTFC_ASSERT_NEVER(a_finish_busy, cmd.finish && sts.out_busy, "result overwrote pending output")
    `FTFC_ASSERT(a_cmp_after_read, st_reg == S_COMPARE |-> $past(st_reg) == S_READ, "compare without read")
    `FTFC_ASSERT_NEVER(a_found_and_step, cmd.set_found && cmd.inc_idx, "index moved past a hit")
endmodule

// ----- hdl/ftfc_dp.sv -----
// ----------------------------------------------------------------------------
// Firewall classifier datapath
// Item registers, bank counts, rule memory, scan index and output register.
// ----------------------------------------------------------------------------
module ftfc_dp (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [127:0]   s_tdata,
    input  logic [1:0]     s_tuser,
    input  ftfc_pkg::cmd_t cmd,
    output ftfc_pkg::sts_t sts,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [23:0]    m_tdata,
    output logic [2:0]     m_tuser
);
    import ftfc_pkg::*;

    req_t              req_reg;
    logic [15:0]       eth_reg;
    logic [63:0]       addrs_reg;
    logic [39:0]       ppp_reg;
    logic [7:0]        act_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              found_reg, found_next;
    logic [7:0]        found_act_reg, found_act_next;
    logic              bank_reg, bank_next;
    logic [CNT_W-1:0]  active_cnt_reg, active_cnt_next;
    logic [CNT_W-1:0]  pending_cnt_reg, pending_cnt_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_kind_reg, out_kind_next;
    logic [23:0]       out_data_reg, out_data_next;

    logic              in_l4;
    logic [7:0]        in_proto;
    logic              tbl_bank;
    logic [CNT_W-1:0]  tbl_cnt;
    logic              tbl_full;
    logic              is_add;
    logic [ROW_W-1:0]  rd_row;
    logic              wr_en;
    logic [RAM_AW-1:0] wr_addr;
    logic              res_hit;
    logic [7:0]        res_act;
    logic [CNT_W-1:0]  res_held;

    // capture the transaction, zero ports of a non TCP/UDP packet to classify
    assign in_proto = s_tdata[119:112];
    assign in_l4    = (in_proto == PROTO_TCP) || (in_proto == PROTO_UDP);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg   <= req_t'(s_tuser);
            eth_reg   <= s_tdata[15:0];
            addrs_reg <= {s_tdata[47:16], s_tdata[79:48]};
            if (req_t'(s_tuser) == REQ_CLASSIFY && !in_l4) begin
                ppp_reg <= {32'd0, in_proto};
            end else begin
                ppp_reg <= {s_tdata[95:80], s_tdata[111:96], in_proto};
            end
            act_reg   <= s_tdata[127:120];
        end
    end

    // select the bank the transaction touches
    assign is_add   = (req_reg == REQ_ADD_PENDING) || (req_reg == REQ_ADD_ACTIVE);
    assign tbl_bank = (req_reg == REQ_ADD_PENDING) ? ~bank_reg : bank_reg;
    assign tbl_cnt  = (req_reg == REQ_ADD_PENDING) ? pending_cnt_reg : active_cnt_reg;
    assign tbl_full = tbl_cnt >= CNT_W'(TABLE_ENTRIES);

    // rule memory: row is {action, ports and protocol, addresses}
    assign wr_en   = cmd.finish && is_add && (found_reg || !tbl_full);
    assign wr_addr = {tbl_bank, found_reg ? idx_reg : tbl_cnt[IDX_W-1:0]};

    ftfc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (RAM_DEPTH)
    ) u_rules (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({act_reg, ppp_reg, addrs_reg}),
        .rd_addr ({tbl_bank, idx_reg}),
        .rd_data (rd_row)
    );

    // status toward the controller
    always_comb begin
        sts.direct   = (req_reg == REQ_COMMIT) ||
                       (req_reg == REQ_CLASSIFY && eth_reg != ETH_IPV4);
        sts.empty    = tbl_cnt == '0;
        sts.match    = rd_row[KEY_W-1:0] == {ppp_reg, addrs_reg};
        sts.last     = (CNT_W'(idx_reg) + CNT_W'(1)) >= tbl_cnt;
        sts.out_busy = out_valid_reg && !m_tready;
    end

    // result of the finished transaction
    always_comb begin
        out_kind_next    = out_kind_reg;
        res_hit          = 1'b0;
        res_act          = 8'd0;
        res_held         = tbl_cnt;
        bank_next        = bank_reg;
        active_cnt_next  = active_cnt_reg;
        pending_cnt_next = pending_cnt_reg;
        unique case (req_reg)
            REQ_COMMIT: begin
                out_kind_next    = RES_COMMITTED;
                bank_next        = ~bank_reg;
                active_cnt_next  = pending_cnt_reg;
                pending_cnt_next = '0;
                res_held         = pending_cnt_reg;
            end
            REQ_CLASSIFY: begin
                if (eth_reg != ETH_IPV4) begin
                    out_kind_next = RES_NOT_IPV4;
                end else if (found_reg) begin
                    out_kind_next = (found_act_reg == ACTION_BLOCK) ? RES_DROP : RES_FORWARD;
                    res_hit       = 1'b1;
                    res_act       = found_act_reg;
                end else begin
                    out_kind_next = RES_FORWARD;
                end
            end
            REQ_ADD_PENDING, REQ_ADD_ACTIVE: begin
                if (found_reg) begin
                    out_kind_next = RES_REPLACED;
                end else if (tbl_full) begin
                    out_kind_next = RES_FULL;
                end else begin
                    out_kind_next = RES_STORED;
                    res_held      = tbl_cnt + CNT_W'(1);
                    if (req_reg == REQ_ADD_PENDING) pending_cnt_next = res_held;
                    else active_cnt_next = res_held;
                end
            end
            default: ;
        endcase
        out_data_next = {4'd0, HELD_W'(res_held), res_act, res_hit};
    end

    // scan index and hit capture
    always_comb begin
        idx_next       = idx_reg;
        found_next     = found_reg;
        found_act_next = found_act_reg;
        if (cmd.clr_idx) begin
            idx_next   = '0;
            found_next = 1'b0;
        end else if (cmd.inc_idx) begin
            idx_next = idx_reg + IDX_W'(1);
        end
        if (cmd.set_found) begin
            found_next     = 1'b1;
            found_act_next = rd_row[ROW_W-1:KEY_W];
        end
    end

    // hold output until taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.finish) out_valid_next = 1'b1;
        else if (m_tready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg        <= 1'b0;
            active_cnt_reg  <= '0;
            pending_cnt_reg <= '0;
            out_valid_reg   <= 1'b0;
            found_reg       <= 1'b0;
        end else begin
            if (cmd.finish) begin
                bank_reg        <= bank_next;
                active_cnt_reg  <= active_cnt_next;
                pending_cnt_reg <= pending_cnt_next;
            end
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        found_act_reg <= found_act_next;
        if (cmd.finish) begin
            out_kind_reg <= out_kind_next;
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
endmodule

// ----- hdl/five_tuple_firewall_classifier_top.sv -----
// ----------------------------------------------------------------------------
// Five-tuple firewall classifier
// Two-bank exact-match rule tables with add, commit and packet lookup.
// ----------------------------------------------------------------------------
//  channel | direction | tdata / tuser
//  s_      | in        | tdata: ethertype, source IP, destination IP, src_l4_port,
//          |           |        dst_l4_port, ip_protocol, rule_action; tuser: req_type
//  m_      | out       | tdata: hit, found_action, rules_held; tuser: result_kind
//
//  A commit, a non-IPv4 packet or a request on an empty bank goes from decode
//  straight to finish without reading the rule memory.
//  Adds and lookups scan the selected bank linearly through the rule memory
//  read port, a read state then a compare state per entry, to a match or the last entry.
//  Rule validity follows the bank fill count, so no clearing pass follows reset.
//  A stalled result holds in the output register; a new transaction is taken
//  once the previous result is registered.
// ----------------------------------------------------------------------------
module five_tuple_firewall_classifier_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // ethertype, source IP, destination IP, src_l4_port,
                                    // dst_l4_port, ip_protocol, rule_action
    input  logic [1:0]   s_tuser,   // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,   // hit, found_action, rules_held, zero pad
    output logic [2:0]   m_tuser    // result_kind
);
    import ftfc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ftfc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ftfc_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Firewall classifier testbench
// Drives rule adds, commits and packet lookups through the input stream with
// random gaps and result stalls, predicts every result from a two-bank rule
// table model, and checks each result transaction field by field.
// ----------------------------------------------------------------------------
module tb;
    import ftfc_pkg::*;

    localparam int CYCLE_LIMIT = 20000000;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [7:0]  proto;
    } tuple_t;

    typedef struct {
        res_t        kind;
        logic        hit;
        logic [7:0]  act;
        logic [10:0] held;
    } verdict_t;

    // Two-bank rule table predictor with a queue of expected verdicts
    class rule_scoreboard;
        logic [7:0]  rules [logic [104:0]];
        int          count [2];
        bit          active;
        verdict_t    verdicts [$];

        function new();
            count[0] = 0;
            count[1] = 0;
            active   = 0;
        endfunction

        function void note_input(req_t req, logic [15:0] eth, tuple_t k, logic [7:0] a);
            verdict_t    v;
            logic [104:0] idx;
            logic [104:0] keys [$];
            bit           b;
            v.hit = 1'b0;
            v.act = 8'd0;
            case (req)
                REQ_COMMIT: begin
                    // empty the old active bank, then swap
                    foreach (rules[i]) if (i[104] == active) keys.push_back(i);
                    foreach (keys[j]) rules.delete(keys[j]);
                    count[active] = 0;
                    active = ~active;
                    v.kind = RES_COMMITTED;
                    v.held = 11'(count[active]);
                end
                REQ_CLASSIFY: begin
                    v.held = 11'(count[active]);
                    if (eth != ETH_IPV4) begin
                        v.kind = RES_NOT_IPV4;
                    end else begin
                        if (k.proto != PROTO_TCP && k.proto != PROTO_UDP) begin
                            k.sp = '0;
                            k.dp = '0;
                        end
                        idx = {active, k};
                        if (rules.exists(idx)) begin
                            v.hit  = 1'b1;
                            v.act  = rules[idx];
                            v.kind = (v.act == ACTION_BLOCK) ? RES_DROP : RES_FORWARD;
                        end else begin
                            v.kind = RES_FORWARD;
                        end
                    end
                end
                default: begin
                    b   = (req == REQ_ADD_PENDING) ? ~active : active;
                    idx = {b, k};
                    if (rules.exists(idx)) begin
                        rules[idx] = a;
                        v.kind = RES_REPLACED;
                    end else if (count[b] >= TABLE_ENTRIES) begin
                        v.kind = RES_FULL;
                    end else begin
                        rules[idx] = a;
                        count[b]++;
                        v.kind = RES_STORED;
                    end
                    v.held = 11'(count[b]);
                end
            endcase
            verdicts.push_back(v);
        endfunction

        // Returns 1 when the result matches the oldest expectation
        function bit check_result(logic [2:0] kind, logic hit, logic [7:0] act,
                                  logic [10:0] held, output string msg);
            verdict_t v;
            if (verdicts.size() == 0) begin
                msg = "result with nothing expected";
                return 0;
            end
            v = verdicts.pop_front();
            if (kind !== v.kind || hit !== v.hit || act !== v.act || held !== v.held) begin
                $sformat(msg, "got kind %0d hit %0d act %0d held %0d, want %0d %0d %0d %0d",
                         kind, hit, act, held, v.kind, v.hit, v.act, v.held);
                return 0;
            end
            return 1;
        endfunction
    endclass

    logic         aclk     = 0;
    logic         aresetn  = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [127:0] s_tdata  = '0;
    logic [1:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [23:0]  m_tdata;
    logic [2:0]   m_tuser;

    rule_scoreboard sb = new();
    int     error_count = 0;
    int     in_flight   = 0;
    int     cycle_count = 0;
    bit     no_idle     = 0;
    bit     hold_req    = 0;
    tuple_t key_pool [$];

    five_tuple_firewall_classifier_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Abort on a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report(string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Offer one transaction after a random gap and hold it until accepted
    task automatic send(req_t req, logic [15:0] eth, tuple_t k, logic [7:0] a);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= req;
        s_tdata  <= {a, k.proto, k.dp, k.sp, k.dst, k.src, eth};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(req, eth, k, a);
        in_flight++;
    endtask

    task automatic go_idle();
        s_tvalid <= 0;
        @(posedge aclk);
        wait (in_flight == 0);
        repeat (10) @(posedge aclk);
    endtask

    function automatic tuple_t rand_tuple();
        tuple_t k;
        k.src   = $urandom;
        k.dst   = $urandom;
        k.sp    = 16'($urandom);
        k.dp    = 16'($urandom);
        case ($urandom_range(0, 3))
            0:       k.proto = PROTO_TCP;
            1:       k.proto = PROTO_UDP;
            default: k.proto = 8'($urandom);
        endcase
        // rules for other protocols only match with zero ports
        if (k.proto != PROTO_TCP && k.proto != PROTO_UDP && $urandom_range(0, 2) != 0) begin
            k.sp = '0;
            k.dp = '0;
        end
        return k;
    endfunction

    function automatic logic [7:0] rand_action();
        case ($urandom_range(0, 3))
            0:       return ACTION_BLOCK;
            1:       return 8'd0;
            default: return 8'($urandom);
        endcase
    endfunction

    // Pick a known key most of the time so lookups and replaces hit
    function automatic tuple_t pick_tuple();
        if (key_pool.size() > 0 && $urandom_range(0, 9) < 6)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return rand_tuple();
    endfunction

    task automatic random_item();
        tuple_t     k;
        int         r;
        logic [15:0] eth;
        k = pick_tuple();
        r = $urandom_range(0, 99);
        if (r < 28) begin
            send(REQ_ADD_PENDING, 16'($urandom), k, rand_action());
            key_pool.push_back(k);
        end else if (r < 38) begin
            send(REQ_ADD_ACTIVE, 16'($urandom), k, rand_action());
            key_pool.push_back(k);
        end else if (r < 42) begin
            send(REQ_COMMIT, 16'($urandom), rand_tuple(), 8'($urandom));
        end else begin
            eth = ($urandom_range(0, 9) == 0) ? 16'($urandom) : ETH_IPV4;
            // non-TCP/UDP packets carry raw transport bytes that must be ignored
            if (k.proto != PROTO_TCP && k.proto != PROTO_UDP && $urandom_range(0, 1)) begin
                k.sp = 16'($urandom);
                k.dp = 16'($urandom);
            end
            send(REQ_CLASSIFY, eth, k, 8'($urandom));
        end
        if (key_pool.size() > 64) void'(key_pool.pop_front());
    endtask

    // Result side: random stalls, one long hold-off on request
    initial begin
        int    stall;
        string msg;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                m_tready <= 0;
                repeat (400) @(posedge aclk);
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 13);
                if (stall > 0) begin
                    m_tready <= 0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1;
            do @(posedge aclk); while (!m_tvalid);
            if (!sb.check_result(m_tuser, m_tdata[0], m_tdata[8:1], m_tdata[19:9], msg))
                report(msg);
            if (in_flight > 0) in_flight--;
        end
    end

    // Stimulus
    initial begin
        tuple_t k, kz;
        int     n;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes, every request and the special lookup cases
        k  = '{src: 32'hFFFF_FFFF, dst: 32'h0, sp: 16'hFFFF, dp: 16'h0, proto: PROTO_TCP};
        kz = '{src: 32'h0A00_0001, dst: 32'hC0A8_0101, sp: 16'h0, dp: 16'h0, proto: 8'd1};
        send(REQ_CLASSIFY, ETH_IPV4, k, 8'h0);             // miss on empty table
        send(REQ_ADD_ACTIVE, 16'h0, k, ACTION_BLOCK);
        send(REQ_CLASSIFY, ETH_IPV4, k, 8'hFF);            // drop
        send(REQ_ADD_ACTIVE, 16'hFFFF, k, 8'hFF);          // replace action
        send(REQ_CLASSIFY, ETH_IPV4, k, 8'h0);             // forward on hit
        send(REQ_CLASSIFY, 16'h0008, k, 8'h0);             // byte-swapped ethertype
        send(REQ_CLASSIFY, 16'hFFFF, k, 8'h0);
        send(REQ_CLASSIFY, 16'h0000, k, 8'h0);
        send(REQ_ADD_ACTIVE, ETH_IPV4, kz, 8'h0);
        kz.sp = 16'hFFFF; kz.dp = 16'hA5A5;
        send(REQ_CLASSIFY, ETH_IPV4, kz, 8'h0);            // ports ignored, hit
        send(REQ_ADD_ACTIVE, ETH_IPV4, kz, ACTION_BLOCK);  // rule keeps its ports
        send(REQ_CLASSIFY, ETH_IPV4, kz, 8'h0);            // still the zero-port rule
        kz.proto = PROTO_UDP;
        send(REQ_CLASSIFY, ETH_IPV4, kz, 8'h0);            // miss under UDP
        send(REQ_ADD_PENDING, ETH_IPV4, kz, ACTION_BLOCK);
        send(REQ_ADD_PENDING, ETH_IPV4, kz, 8'h7F);        // replace in pending
        send(REQ_CLASSIFY, ETH_IPV4, kz, 8'h0);            // pending not yet live
        send(REQ_COMMIT, 16'hFFFF, '1, 8'hFF);
        send(REQ_CLASSIFY, ETH_IPV4, kz, 8'h0);
        send(REQ_CLASSIFY, ETH_IPV4, k, 8'h0);             // old rules gone
        send(REQ_COMMIT, 16'h0, '0, 8'h0);                 // active becomes empty
        send(REQ_CLASSIFY, ETH_IPV4, kz, 8'h0);

        // random: phases with and without idling, one long result hold-off
        for (n = 0; n < 600; n++) begin
            if (n % 200 == 0) no_idle = (n / 200) % 3 == 2;
            if (n == 250) hold_req = 1;
            if (n == 380) go_idle();
            random_item();
        end

        // fill the pending table, overflow it, then commit it live
        go_idle();
        no_idle = 1;
        send(REQ_COMMIT, 16'h0, '0, 8'h0);
        for (n = 0; n < TABLE_ENTRIES; n++) begin
            k = '{src: $urandom, dst: 32'(n), sp: 16'($urandom), dp: 16'($urandom),
                  proto: PROTO_TCP};
            send(REQ_ADD_PENDING, ETH_IPV4, k, 8'(n));
        end
        send(REQ_ADD_PENDING, ETH_IPV4, rand_tuple(), ACTION_BLOCK);   // full
        send(REQ_ADD_PENDING, ETH_IPV4, k, ACTION_BLOCK);              // replace when full
        send(REQ_ADD_PENDING, ETH_IPV4, rand_tuple(), 8'h2);          // full
        no_idle = 0;
        send(REQ_COMMIT, 16'h0, '0, 8'h0);
        send(REQ_CLASSIFY, ETH_IPV4, k, 8'h0);
        send(REQ_ADD_ACTIVE, ETH_IPV4, rand_tuple(), 8'h3);           // full
        send(REQ_CLASSIFY, ETH_IPV4, rand_tuple(), 8'h0);
        send(REQ_COMMIT, 16'h0, '0, 8'h0);
        send(REQ_CLASSIFY, ETH_IPV4, k, 8'h0);

        // drain
        s_tvalid <= 0;
        @(posedge aclk);
        wait (in_flight == 0);
        repeat (50) @(posedge aclk);
        if (error_count == 0 && sb.verdicts.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
